@@ hw/rtl/tcw_pkg.sv @@
// Shared types and constants for the text console character writer.
package tcw_pkg;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 16;
  localparam int CHAR_W = 8;

  localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_NL  = 8'h0A;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0020;

  localparam int CFG_IDX_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEXT_COLOR    = 8'd0,
    REG_BLINK_ENABLE  = 8'd1,
    REG_BRIGHT_ENABLE = 8'd2,
    REG_SCROLL_ENABLE = 8'd3
  } tcw_reg_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } tcw_pos_t;

endpackage

@@ hw/rtl/tcw_ram.sv @@
// Generic simple dual-port RAM with registered read.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/tcw_addr.sv @@
// Shared address unit: row-major cell address from a row and column.
module tcw_addr
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int AW      = 11
) (
  input  tcw_pos_t        pos,
  output logic [AW-1:0]   addr
);

  logic [AW-1:0] row_ext;
  logic [AW-1:0] col_ext;

  assign row_ext = AW'(pos.row);
  assign col_ext = AW'(pos.col);
  assign addr    = AW'(row_ext * AW'(COLUMNS)) + col_ext;

endmodule

@@ hw/rtl/text_console_character_writer.sv @@
// Text console character writer: top level with cursor sequencer.
//
// Input items (in_*) carry a mode in tuser (0 put character, 1 read a cell)
// and the character code, read row and read column in tdata. Each item
// gives exactly one result on out_*: cursor column and row after the item,
// the read cell (0 in put mode or out of range) and a scrolled flag.
// Configuration writes (cfg_*) set the color, blink, bright and scroll
// registers; cfg_ready is always high, writes belong to idle periods.
// The screen lives in one RAM with one write and one registered read port;
// puts and reads address it through the row*COLUMNS+col unit, while clear
// and scroll step a counter. out_tvalid rises the cycle after a put that
// does not scroll is accepted; a read passes through S_READ first.
// A scroll walks the RAM: each moved cell is read in S_SCR_RD and written
// a row up in S_SCR_WR, then S_BLANK blanks the last row.
// After reset the block sweeps all COLUMNS*ROWS cells clearing the screen to
// zero; in_tready stays low meanwhile. The result is held in an output
// register until out_tready; no new item is taken until it is delivered.
module text_console_character_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [23:0]          in_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13]
  input  logic                 in_tuser,   // mode
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,  // cursor_col[6:0], cursor_row[11:7],
                                           // read_data[27:12], scrolled[28]
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int PH_W  = $clog2(TAB_STOP);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_READ   = 7'b0000100,
    S_SCR_RD = 7'b0001000,
    S_SCR_WR = 7'b0010000,
    S_BLANK  = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     cnt_r, cnt_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [PH_W-1:0]   ph_r, ph_nxt;
  logic              scr_r, scr_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic [CELL_W-1:0] data_r, data_nxt;
  logic [7:0]        color_r;
  logic              blink_r, bright_r, scroll_en_r;

  logic [CHAR_W-1:0] in_char;
  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  in_col;

  tcw_pos_t          pos;
  logic [AW-1:0]     addr_u;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  logic              do_nl;
  logic [7:0]        col_inc;
  logic [7:0]        tab_stop_col;
  logic [7:0]        attr;

  assign in_char = in_tdata[7:0];
  assign in_row  = in_tdata[12:8];
  assign in_col  = in_tdata[19:13];

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {3'b000, scr_r, data_r, row_r, col_r};
  assign cfg_ready  = 1'b1;

  assign col_inc      = {1'b0, col_r} + 8'd1;
  assign tab_stop_col = {1'b0, col_r} + 8'(TAB_STOP) - 8'(ph_r);
  assign attr         = color_r | {blink_r, 3'b000, bright_r, 3'b000};

  tcw_addr #(
    .COLUMNS(COLUMNS),
    .AW     (AW)
  ) u_addr (
    .pos (pos),
    .addr(addr_u)
  );

  tcw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    ph_nxt    = ph_r;
    scr_nxt   = scr_r;
    rd_ok_nxt = rd_ok_r;
    data_nxt  = data_r;
    pos       = '{row: row_r, col: col_r};
    ram_we    = 1'b0;
    ram_waddr = cnt_r;
    ram_wdata = '0;
    ram_raddr = cnt_r + AW'(COLUMNS);
    do_nl     = 1'b0;

    case (state_r)
      S_CLEAR: begin
        ram_we  = 1'b1;
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == AW'(CELLS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          scr_nxt   = 1'b0;
          data_nxt  = '0;
          state_nxt = S_OUT;
          if (in_tuser) begin
            pos       = '{row: in_row, col: in_col};
            ram_raddr = addr_u;
            rd_ok_nxt = ({1'b0, in_row} < 6'(ROWS)) && ({1'b0, in_col} < 8'(COLUMNS));
            state_nxt = S_READ;
          end else begin
            case (in_char)
              CHAR_NUL: begin
              end
              CHAR_NL: begin
                do_nl = 1'b1;
              end
              CHAR_TAB: begin
                if (ph_r != '0) begin
                  if (tab_stop_col < 8'(COLUMNS)) begin
                    col_nxt = tab_stop_col[COL_W-1:0];
                    ph_nxt  = '0;
                  end else begin
                    do_nl = 1'b1;
                  end
                end
              end
              default: begin
                ram_we    = 1'b1;
                ram_waddr = addr_u;
                ram_wdata = {attr, in_char};
                if (col_inc >= 8'(COLUMNS)) begin
                  do_nl = 1'b1;
                end else begin
                  col_nxt = col_inc[COL_W-1:0];
                  ph_nxt  = (ph_r == PH_W'(TAB_STOP - 1)) ? '0 : ph_r + PH_W'(1);
                end
              end
            endcase
            if (do_nl) begin
              col_nxt = '0;
              ph_nxt  = '0;
              if (row_r == ROW_W'(ROWS - 1)) begin
                if (scroll_en_r) begin
                  scr_nxt   = 1'b1;
                  cnt_nxt   = '0;
                  state_nxt = S_SCR_RD;
                end else begin
                  row_nxt = '0;
                end
              end else begin
                row_nxt = row_r + ROW_W'(1);
              end
            end
          end
        end
      end
      S_READ: begin
        data_nxt  = rd_ok_r ? ram_rdata : '0;
        state_nxt = S_OUT;
      end
      S_SCR_RD: begin
        state_nxt = S_SCR_WR;
      end
      S_SCR_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        cnt_nxt   = cnt_r + AW'(1);
        state_nxt = (cnt_r == AW'(CELLS - COLUMNS - 1)) ? S_BLANK : S_SCR_RD;
      end
      S_BLANK: begin
        ram_we    = 1'b1;
        ram_wdata = BLANK_CELL;
        cnt_nxt   = cnt_r + AW'(1);
        if (cnt_r == AW'(CELLS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      ph_r        <= '0;
      scr_r       <= 1'b0;
      rd_ok_r     <= 1'b0;
      color_r     <= 8'd7;
      blink_r     <= 1'b0;
      bright_r    <= 1'b0;
      scroll_en_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      ph_r    <= ph_nxt;
      scr_r   <= scr_nxt;
      rd_ok_r <= rd_ok_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_TEXT_COLOR:    color_r     <= cfg_data;
          REG_BLINK_ENABLE:  blink_r     <= cfg_data[0];
          REG_BRIGHT_ENABLE: bright_r    <= cfg_data[0];
          REG_SCROLL_ENABLE: scroll_en_r <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

@@ dv/text_console_character_writer_tb.sv @@
// Self-checking testbench for the text console character writer against a screen model.
`timescale 1ns / 100ps

module text_console_character_writer_tb;
  import tcw_pkg::*;

  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STOP = 8;
  localparam int CELLS    = COLUMNS * ROWS;
  localparam int LIMIT    = 8_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_PRINTED = 20;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = '1;

  typedef struct packed {
    logic              mode;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
  } console_item_t;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [CELL_W-1:0] read_data;
    logic              scrolled;
  } console_result_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [23:0]          in_tdata = '0;
  logic                 in_tuser = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [31:0]          out_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;

  text_console_character_writer #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .TAB_STOP(TAB_STOP)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // screen model
  logic [CELL_W-1:0] screen_model [CELLS];
  int                cur_col;
  int                cur_row;
  logic [7:0]        text_color;
  logic              blink_on;
  logic              bright_on;
  logic              scroll_on;

  console_item_t   pending_chars[$];
  console_result_t awaited_results[$];
  console_item_t   cur_item;
  int              sent_cnt;
  int              accepted_cnt;
  int              live_items;
  int              mismatches;
  int              cycles;
  logic            steady = 1'b0;
  int              hold_ask = 0;
  int              hold_seen;
  int              hold_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic line_feed();
    cur_col = 0;
    cur_row++;
    if (cur_row >= ROWS) begin
      if (scroll_on) begin
        for (int i = 0; i < CELLS - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_model[i] = BLANK_CELL;
        cur_row = ROWS - 1;
        return 1'b1;
      end
      cur_row = 0;
    end
    return 1'b0;
  endfunction

  task automatic apply_char(input console_item_t it);
    console_result_t r;
    logic [7:0]      attr;
    int              stop;
    r = '0;
    if (it.mode) begin
      if (it.read_row < ROWS && it.read_col < COLUMNS)
        r.read_data = screen_model[it.read_row * COLUMNS + it.read_col];
    end else if (it.char_code == CHAR_NUL) begin
    end else if (it.char_code == CHAR_NL) begin
      r.scrolled = line_feed();
    end else if (it.char_code == CHAR_TAB) begin
      if (cur_col % TAB_STOP != 0) begin
        stop = (cur_col / TAB_STOP + 1) * TAB_STOP;
        if (stop < COLUMNS) cur_col = stop;
        else r.scrolled = line_feed();
      end
    end else begin
      attr = text_color | {4'b0, bright_on, 3'b0} | {blink_on, 7'b0};
      screen_model[cur_row * COLUMNS + cur_col] = {attr, it.char_code};
      cur_col++;
      if (cur_col >= COLUMNS) r.scrolled = line_feed();
    end
    r.col = COL_W'(cur_col);
    r.row = ROW_W'(cur_row);
    awaited_results.push_back(r);
  endtask

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    case (idx)
      REG_TEXT_COLOR:    text_color = val;
      REG_BLINK_ENABLE:  blink_on = val[0];
      REG_BRIGHT_ENABLE: bright_on = val[0];
      REG_SCROLL_ENABLE: scroll_on = val[0];
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < MAX_PRINTED)
      $display("mismatch on %s: got %0h, want %0h", what, got, want);
    mismatches++;
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        apply_char(cur_item);
        accepted_cnt++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_chars.size() != 0 && (steady || $urandom_range(99) >= 27)) begin
          cur_item = pending_chars.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= cur_item.mode;
          in_tdata  <= {4'b0, cur_item.read_col, cur_item.read_row, cur_item.char_code};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with long hold-offs on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
      hold_seen  <= 0;
    end else if (hold_seen != hold_ask) begin
      hold_seen  <= hold_ask;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady || ($urandom_range(99) >= 27);
    end
  end

  // result checker
  always @(posedge clk) begin
    console_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result with nothing awaited", out_tdata, 0);
      end else begin
        want = awaited_results.pop_front();
        if (out_tdata[6:0] !== want.col) report_mismatch("cursor_col", out_tdata[6:0], want.col);
        if (out_tdata[11:7] !== want.row) report_mismatch("cursor_row", out_tdata[11:7], want.row);
        if (out_tdata[27:12] !== want.read_data)
          report_mismatch("read_data", out_tdata[27:12], want.read_data);
        if (out_tdata[28] !== want.scrolled)
          report_mismatch("scrolled", out_tdata[28], want.scrolled);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("text_console_character_writer verification failed");
      $finish;
    end
  end

  function automatic logic [CHAR_W-1:0] rand_glyph();
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom_range(1, 255)); while (c == CHAR_TAB || c == CHAR_NL);
    return c;
  endfunction

  task automatic push_item(input logic mode, input logic [CHAR_W-1:0] ch,
                           input int r, input int c);
    console_item_t it;
    it.mode      = mode;
    it.char_code = ch;
    it.read_row  = ROW_W'(r);
    it.read_col  = COL_W'(c);
    pending_chars.push_back(it);
    sent_cnt++;
    if (mode || ch != CHAR_NUL) live_items++;
  endtask

  task automatic push_put(input logic [CHAR_W-1:0] ch);
    push_item(1'b0, ch, $urandom_range(31), $urandom_range(127));
  endtask

  task automatic push_read(input int r, input int c);
    push_item(1'b1, CHAR_W'($urandom_range(255)), r, c);
  endtask

  // one well-formed piece of console text, or a little noise
  task automatic add_segment();
    int roll;
    int n;
    roll = $urandom_range(99);
    if (roll < 40) begin
      n = $urandom_range(6);
      repeat (n) push_put(($urandom_range(99) < 20) ? CHAR_TAB : rand_glyph());
      push_put(CHAR_NL);
    end else if (roll < 55) begin
      n = $urandom_range(12, 30);
      repeat (n) push_put(($urandom_range(99) < 40) ? CHAR_TAB : rand_glyph());
    end else if (roll < 75) begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        if ($urandom_range(99) < 50) push_read($urandom_range(ROWS - 5, ROWS - 1),
                                               $urandom_range(COLUMNS - 1));
        else if ($urandom_range(99) < 60) push_read($urandom_range(ROWS - 1),
                                                    $urandom_range(COLUMNS - 1));
        else push_read($urandom_range(31), $urandom_range(127));
      end
    end else if (roll < 85) begin
      n = $urandom_range(1, 3);
      repeat (n) push_put(CHAR_NL);
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) push_item(1'($urandom_range(1)), CHAR_W'($urandom_range(255)),
                           $urandom_range(31), $urandom_range(127));
    end
  endtask

  task automatic add_random(input int n);
    int target;
    target = live_items + n;
    while (live_items < target) add_segment();
  endtask

  task automatic drain();
    while (accepted_cnt != sent_cnt || awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int hold_mark;
    foreach (screen_model[i]) screen_model[i] = '0;
    cur_col      = 0;
    cur_row      = 0;
    text_color   = 8'h07;
    blink_on     = 1'b0;
    bright_on    = 1'b0;
    scroll_on    = 1'b0;
    sent_cnt     = 0;
    accepted_cnt = 0;
    live_items   = 0;
    mismatches   = 0;
    cycles       = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset colors, scroll off
    push_read(0, 0);
    push_put(8'h41);
    push_put(8'hFF);
    push_put(8'h01);
    push_put(CHAR_NUL);
    push_put(CHAR_TAB);
    push_put(CHAR_TAB);
    push_put(CHAR_NL);
    push_item(1'b1, CHAR_NL, 0, 0);
    push_read(0, 1);
    push_read(0, 2);
    push_read(0, 3);
    push_read(ROWS - 1, COLUMNS - 1);
    push_read(ROWS, 0);
    push_read(0, COLUMNS);
    push_read(31, 127);
    push_put(8'h20);
    push_put(8'h7E);
    push_read(1, 0);
    add_random(150);
    drain();

    // bright blinking white on white, scrolling; long receiver hold-off
    write_reg(REG_TEXT_COLOR, 8'hFF);
    write_reg(REG_BLINK_ENABLE, 8'h01);
    write_reg(REG_BRIGHT_ENABLE, 8'h01);
    write_reg(REG_SCROLL_ENABLE, 8'h01);
    hold_mark = accepted_cnt + 30;
    add_random(180);
    while (accepted_cnt < hold_mark) @(posedge clk);
    hold_ask <= hold_ask + 1;
    drain();

    // masked values and an unknown index, no idling on either side
    write_reg(REG_TEXT_COLOR, 8'h00);
    write_reg(REG_BLINK_ENABLE, 8'hFE);
    write_reg(REG_UNUSED, 8'hFF);
    write_reg(REG_SCROLL_ENABLE, 8'h03);
    steady <= 1'b1;
    add_random(120);
    drain();
    steady <= 1'b0;

    write_reg(REG_TEXT_COLOR, 8'($urandom_range(255)));
    write_reg(REG_BLINK_ENABLE, 8'h01);
    write_reg(REG_BRIGHT_ENABLE, 8'h00);
    write_reg(REG_SCROLL_ENABLE, 8'h00);
    add_random(100);
    drain();

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("text_console_character_writer verification clean");
    end else begin
      $display("text_console_character_writer verification failed");
    end
    $finish;
  end

endmodule
